[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; used by every module under rtl/.
`default_nettype none

package spq_pkg;

  // Default sizing, handed down from the top level
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int DEF_VALUE_BITS    = 32;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  // Operation codes; code 3 carries no meaning and is a no-op
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } opcode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // apply the captured request and register the result
  } spq_cmd_t;

endpackage

`default_nettype wire

[rtl/spq_ctrl.sv]
// Controller for the sorted priority queue: request handshake and sequencing.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output spq_pkg::spq_cmd_t     cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) state_nxt = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        state_nxt = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        cmd.load = start;
      end
      spq_pkg::S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/spq_dpath.sv]
// Datapath for the sorted priority queue: request registers, sorted row of
// entries with per-entry compare and neighbor shift, result registers.
// Depends on spq_pkg.
`default_nettype none

module spq_dpath #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
  parameter int VALUE_BITS    = spq_pkg::DEF_VALUE_BITS,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spq_pkg::spq_cmd_t             cmd,
  input  wire logic [spq_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire logic signed [VALUE_BITS-1:0]  in_item_value,
  input  wire logic [PRIORITY_BITS-1:0]      in_item_priority,
  output logic                               out_valid,
  output logic signed [VALUE_BITS-1:0]       out_head_value,
  output logic [spq_pkg::STATUS_W-1:0]       out_status,
  output logic [CNT_W-1:0]                   out_entry_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Captured request
  logic [spq_pkg::OPCODE_W-1:0] op_r;
  logic [VALUE_BITS-1:0]        val_r;
  logic [PRIORITY_BITS-1:0]     prio_r;

  // Entry row; entries at or beyond the count hold don't-care data
  logic [VALUE_BITS-1:0]    ent_val_r  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] ent_prio_r [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0]    ent_val_nxt  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] ent_prio_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;

  // Result registers
  logic                         out_valid_r;
  logic [VALUE_BITS-1:0]        head_r;
  logic [VALUE_BITS-1:0]        head_nxt;
  logic [spq_pkg::STATUS_W-1:0] status_r;
  logic [spq_pkg::STATUS_W-1:0] status_nxt;

  logic [QUEUE_DEPTH-1:0] stays;     // valid entry with strictly smaller priority
  logic                   is_full;
  logic                   is_empty;
  logic                   do_insert;
  logic                   do_remove;

  assign is_full  = (cnt_r == FULL_CNT);
  assign is_empty = (cnt_r == '0);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      val_r  <= in_item_value;
      prio_r <= in_item_priority;
    end
  end

  // Operation decode and result
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    head_nxt   = '0;
    status_nxt = spq_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    case (spq_pkg::opcode_t'(op_r))
      spq_pkg::OP_INSERT: begin
        if (is_full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (is_empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          head_nxt  = ent_val_r[0];
          do_remove = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      spq_pkg::OP_PEEK: begin
        if (is_empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          head_nxt = ent_val_r[0];
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_OK;
      end
    endcase
  end

  // Per-entry compare and neighbor selection
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_ent
    logic                     prev_stays;
    logic [VALUE_BITS-1:0]    up_val;
    logic [PRIORITY_BITS-1:0] up_prio;
    logic [VALUE_BITS-1:0]    dn_val;
    logic [PRIORITY_BITS-1:0] dn_prio;

    assign stays[g] = (CNT_W'(g) < cnt_r) && (ent_prio_r[g] < prio_r);

    if (g == 0) begin : g_first
      assign prev_stays = 1'b1;
      assign dn_val     = val_r;
      assign dn_prio    = prio_r;
    end else begin : g_rest
      assign prev_stays = stays[g-1];
      assign dn_val     = ent_val_r[g-1];
      assign dn_prio    = ent_prio_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign up_val  = ent_val_r[g];
      assign up_prio = ent_prio_r[g];
    end else begin : g_inner
      assign up_val  = ent_val_r[g+1];
      assign up_prio = ent_prio_r[g+1];
    end

    // Insert: keep if ahead, take new at the boundary, else shift down; remove: shift up
    always_comb begin
      ent_val_nxt[g]  = ent_val_r[g];
      ent_prio_nxt[g] = ent_prio_r[g];
      if (do_insert && !stays[g]) begin
        if (prev_stays) begin
          ent_val_nxt[g]  = val_r;
          ent_prio_nxt[g] = prio_r;
        end else begin
          ent_val_nxt[g]  = dn_val;
          ent_prio_nxt[g] = dn_prio;
        end
      end else if (do_remove) begin
        ent_val_nxt[g]  = up_val;
        ent_prio_nxt[g] = up_prio;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        ent_val_r[g]  <= ent_val_nxt[g];
        ent_prio_r[g] <= ent_prio_nxt[g];
      end
    end
  end

  // Occupancy and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) cnt_r <= cnt_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      head_r   <= head_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_value  = head_r;
  assign out_status      = status_r;
  assign out_entry_count = cnt_r;

endmodule

`default_nettype wire

[rtl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
`default_nettype none

// Bounded priority queue kept sorted, lowest priority number at the head; a
// new entry goes ahead of stored entries of equal priority. A request is
// taken when start is high and busy is low; busy is then high for one cycle
// while the whole row of entries compares and shifts in parallel, and the
// result appears on the out_ ports for exactly one cycle, marked by out_valid,
// in the cycle after. The next request may be issued in the cycle its
// predecessor's result is shown. The result cannot be held off:
// the receiver must take it in that cycle. out_entry_count is the number of
// entries held after the request; out_head_value is zero unless a remove or
// peek found an entry.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
  parameter int VALUE_BITS    = spq_pkg::DEF_VALUE_BITS,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [spq_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire logic signed [VALUE_BITS-1:0]  in_item_value,
  input  wire logic [PRIORITY_BITS-1:0]      in_item_priority,
  output logic                               out_valid,
  output logic signed [VALUE_BITS-1:0]       out_head_value,
  output logic [spq_pkg::STATUS_W-1:0]       out_status,
  output logic [CNT_W-1:0]                   out_entry_count
);

  spq_pkg::spq_cmd_t cmd;

  // Sequencing
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Entry storage and result
  spq_dpath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_head_value   (out_head_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

endmodule

`default_nettype wire
